/* design/ige_pkg.sv */
// Shared types and constants for the Ising ground-state engine.
package ige_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_EVAL   = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_REFINE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_t;

  localparam int ENERGY_W   = 13;
  localparam int SPIN_OUT_W = 8;
  localparam int COUPLING_W = 8;
  localparam int INDEX_W    = 3;
  localparam int PASS_W     = 16;

  localparam logic [PASS_W-1:0]          PASS_RESET = 16'd5000;
  localparam logic signed [ENERGY_W-1:0] ENERGY_MAX = 13'h0FFF;
  localparam logic signed [ENERGY_W-1:0] ENERGY_MIN = 13'h1000;

  typedef struct packed {
    logic                       valid;
    logic signed [ENERGY_W-1:0] energy;
    logic [SPIN_OUT_W-1:0]      spins;
  } result_t;

endpackage

/* design/ige_coupling_mem.sv */
// Coupling store: one entry per ordered pair address, valid bits clear on reset.
module ige_coupling_mem #(
  parameter int ADDR_W = 6
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wen,
  input  logic [ADDR_W-1:0]                     waddr,
  input  logic signed [ige_pkg::COUPLING_W-1:0] wdata,
  input  logic [ADDR_W-1:0]                     raddr,
  output logic signed [ige_pkg::COUPLING_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic signed [ige_pkg::COUPLING_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]                      valid;
  logic signed [ige_pkg::COUPLING_W-1:0] mem_q;
  logic                                  valid_q;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wen) begin
        valid[waddr] <= 1'b1;
      end
      valid_q <= valid[raddr];
    end
  end

  assign rdata = valid_q ? mem_q : '0;

endmodule

/* design/ige_seq.sv */
// Pair-walk sequencer: energy accumulation, exhaustive search and greedy refinement.
module ige_seq #(
  parameter int SPIN_COUNT = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  ige_pkg::cmd_t                         start_cmd,
  input  logic [SPIN_COUNT-1:0]                 start_spins,
  input  logic [ige_pkg::PASS_W-1:0]            max_passes,
  output logic [2*$clog2(SPIN_COUNT)-1:0]       raddr,
  input  logic signed [ige_pkg::COUPLING_W-1:0] rdata,
  output ige_pkg::result_t                      res,
  input  logic                                  res_ready,
  output logic                                  idle
);

  localparam int IDX_W   = $clog2(SPIN_COUNT);
  localparam int PAIRS   = SPIN_COUNT * (SPIN_COUNT - 1) / 2;
  localparam int ACC_RAW = $clog2(128 * PAIRS + 1) + 1;
  localparam int ACC_W   = (ACC_RAW > ige_pkg::ENERGY_W) ? ACC_RAW : ige_pkg::ENERGY_W;
  localparam int SW      = (SPIN_COUNT > ige_pkg::SPIN_OUT_W) ? SPIN_COUNT : ige_pkg::SPIN_OUT_W;

  localparam logic [IDX_W-1:0] I_LAST = IDX_W'(SPIN_COUNT - 2);
  localparam logic [IDX_W-1:0] J_LAST = IDX_W'(SPIN_COUNT - 1);

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(ige_pkg::ENERGY_MAX);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(ige_pkg::ENERGY_MIN);

  ige_pkg::state_t state, state_next;

  logic                                  searching, searching_next;
  logic                                  refining, refining_next;
  logic                                  issuing, issuing_next;
  logic [IDX_W-1:0]                      i_ptr, i_ptr_next;
  logic [IDX_W-1:0]                      j_ptr, j_ptr_next;
  logic                                  d_valid, d_valid_next;
  logic [IDX_W-1:0]                      d_i, d_i_next;
  logic [IDX_W-1:0]                      d_j, d_j_next;
  logic                                  d_last, d_last_next;
  logic [SPIN_COUNT-1:0]                 spins, spins_next;
  logic signed [ACC_W-1:0]               acc, acc_next;
  logic signed [ACC_W-1:0]               best, best_next;
  logic [ige_pkg::PASS_W-1:0]            passes, passes_next;
  logic                                  flipped, flipped_next;
  logic signed [ige_pkg::ENERGY_W-1:0]   res_energy, res_energy_next;
  logic [ige_pkg::SPIN_OUT_W-1:0]        res_spins, res_spins_next;

  logic                                  pair_last;
  logic                                  same;
  logic                                  flip_cond;
  logic signed [ACC_W-1:0]               c_ext;
  logic signed [ACC_W-1:0]               acc_upd;
  logic signed [ACC_W-1:0]               best_cand;
  logic signed [ACC_W-1:0]               sat_in;
  logic signed [ige_pkg::ENERGY_W-1:0]   sat_out;
  logic [ige_pkg::PASS_W-1:0]            pass_inc;
  logic [SW-1:0]                         spins_wide;

  assign raddr      = {i_ptr, j_ptr};
  assign pair_last  = (i_ptr == I_LAST) && (j_ptr == J_LAST);
  assign same       = spins[d_i] == spins[d_j];
  assign c_ext      = ACC_W'(rdata);
  assign acc_upd    = same ? (acc - c_ext) : (acc + c_ext);
  assign best_cand  = ((spins == '0) || (acc_upd < best)) ? acc_upd : best;
  assign sat_in     = searching ? best_cand : acc_upd;
  assign flip_cond  = ((rdata > 0) && !same) || ((rdata < 0) && same);
  assign pass_inc   = passes + 1'b1;
  assign spins_wide = SW'(spins);

  always_comb begin
    if (sat_in > SAT_MAX) begin
      sat_out = ige_pkg::ENERGY_MAX;
    end else if (sat_in < SAT_MIN) begin
      sat_out = ige_pkg::ENERGY_MIN;
    end else begin
      sat_out = sat_in[ige_pkg::ENERGY_W-1:0];
    end
  end

  always_comb begin
    state_next      = state;
    searching_next  = searching;
    refining_next   = refining;
    issuing_next    = issuing;
    i_ptr_next      = i_ptr;
    j_ptr_next      = j_ptr;
    d_valid_next    = 1'b0;
    d_i_next        = i_ptr;
    d_j_next        = j_ptr;
    d_last_next     = pair_last;
    spins_next      = spins;
    acc_next        = acc;
    best_next       = best;
    passes_next     = passes;
    flipped_next    = flipped;
    res_energy_next = res_energy;
    res_spins_next  = res_spins;

    if (issuing) begin
      d_valid_next = 1'b1;
      if (pair_last) begin
        issuing_next = 1'b0;
      end else if (j_ptr == J_LAST) begin
        i_ptr_next = i_ptr + 1'b1;
        j_ptr_next = i_ptr + IDX_W'(2);
      end else begin
        j_ptr_next = j_ptr + 1'b1;
      end
    end

    unique case (state)
      ige_pkg::S_IDLE: begin
        if (start) begin
          state_next   = ige_pkg::S_RUN;
          issuing_next = 1'b1;
          i_ptr_next   = '0;
          j_ptr_next   = IDX_W'(1);
          acc_next     = '0;
          passes_next  = '0;
          flipped_next = 1'b0;
          unique case (start_cmd)
            ige_pkg::CMD_SEARCH: begin
              searching_next = 1'b1;
              refining_next  = 1'b0;
              spins_next     = '0;
            end
            ige_pkg::CMD_REFINE: begin
              searching_next = 1'b0;
              refining_next  = max_passes != '0;
              spins_next     = start_spins;
            end
            ige_pkg::CMD_EVAL, ige_pkg::CMD_WRITE: begin
              searching_next = 1'b0;
              refining_next  = 1'b0;
              spins_next     = start_spins;
            end
          endcase
        end
      end
      ige_pkg::S_RUN: begin
        if (d_valid) begin
          if (refining) begin
            if (flip_cond) begin
              spins_next[d_i] = ~spins[d_i];
            end
            flipped_next = flipped | flip_cond;
            if (d_last) begin
              passes_next  = pass_inc;
              issuing_next = 1'b1;
              i_ptr_next   = '0;
              j_ptr_next   = IDX_W'(1);
              flipped_next = 1'b0;
              if (!(flipped | flip_cond) || (pass_inc == max_passes)) begin
                refining_next = 1'b0;
                acc_next      = '0;
              end
            end
          end else begin
            acc_next = acc_upd;
            if (d_last) begin
              if (searching) begin
                best_next = best_cand;
                if (spins == '1) begin
                  res_energy_next = sat_out;
                  res_spins_next  = '0;
                  state_next      = ige_pkg::S_HOLD;
                end else begin
                  spins_next   = spins + 1'b1;
                  acc_next     = '0;
                  issuing_next = 1'b1;
                  i_ptr_next   = '0;
                  j_ptr_next   = IDX_W'(1);
                end
              end else begin
                res_energy_next = sat_out;
                res_spins_next  = spins_wide[ige_pkg::SPIN_OUT_W-1:0];
                state_next      = ige_pkg::S_HOLD;
              end
            end
          end
        end
      end
      ige_pkg::S_HOLD: begin
        if (res_ready) begin
          state_next = ige_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ige_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ige_pkg::S_IDLE;
      issuing <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      state   <= state_next;
      issuing <= issuing_next;
      d_valid <= d_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    searching  <= searching_next;
    refining   <= refining_next;
    i_ptr      <= i_ptr_next;
    j_ptr      <= j_ptr_next;
    d_i        <= d_i_next;
    d_j        <= d_j_next;
    d_last     <= d_last_next;
    spins      <= spins_next;
    acc        <= acc_next;
    best       <= best_next;
    passes     <= passes_next;
    flipped    <= flipped_next;
    res_energy <= res_energy_next;
    res_spins  <= res_spins_next;
  end

  assign idle       = state == ige_pkg::S_IDLE;
  assign res.valid  = state == ige_pkg::S_HOLD;
  assign res.energy = res_energy;
  assign res.spins  = res_spins;

endmodule

/* design/ising_ground_state_engine.sv */
// Top level of the Ising ground-state engine: ports, pass-limit register, output word.
//
//   channel  | handshake            | word
//   ---------+----------------------+-------------------------------------------------------
//   input    | in_valid / in_ready  | command, first_index, second_index, coupling_value,
//            |                      | spin_vector
//   output   | out_valid/out_ready  | energy, result_spins
//   config   | cfg_wen              | cfg_wdata (max_passes)
//
// P = SPIN_COUNT*(SPIN_COUNT-1)/2 pairs; the coupling store delivers one pair per cycle.
// A write is stored as it is accepted; evaluate walks the P pairs once; search walks them for
// each of the 2^SPIN_COUNT spin vectors; refine walks them once per pass, then once more to evaluate.
// Reset clears the coupling store valid bits at once and loads max_passes with 5000.
// One input word is in flight at a time; a finished result waits in the output register
// while the next input word is taken.
module ising_ground_state_engine #(
  parameter int SPIN_COUNT = 8
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [1:0]                               command,
  input  logic [ige_pkg::INDEX_W-1:0]              first_index,
  input  logic [ige_pkg::INDEX_W-1:0]              second_index,
  input  logic signed [ige_pkg::COUPLING_W-1:0]    coupling_value,
  input  logic [ige_pkg::SPIN_OUT_W-1:0]           spin_vector,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [ige_pkg::ENERGY_W-1:0]      energy,
  output logic [ige_pkg::SPIN_OUT_W-1:0]           result_spins,
  input  logic                                     cfg_wen,
  input  logic [ige_pkg::PASS_W-1:0]               cfg_wdata
);

  localparam int IDX_W  = $clog2(SPIN_COUNT);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int SW     = (SPIN_COUNT > ige_pkg::SPIN_OUT_W) ? SPIN_COUNT : ige_pkg::SPIN_OUT_W;

  logic [ige_pkg::PASS_W-1:0]            max_passes;
  ige_pkg::cmd_t                         cmd;
  logic                                  accept;
  logic                                  pair_ok;
  logic [31:0]                           a_ext;
  logic [31:0]                           b_ext;
  logic [IDX_W-1:0]                      a_idx;
  logic [IDX_W-1:0]                      b_idx;
  logic                                  wen;
  logic [ADDR_W-1:0]                     waddr;
  logic [ADDR_W-1:0]                     raddr;
  logic signed [ige_pkg::COUPLING_W-1:0] rdata;
  logic [SW-1:0]                         vin_wide;
  ige_pkg::result_t                      res;
  logic                                  res_ready;
  logic                                  idle;
  logic                                  out_valid_next;

  assign cmd      = ige_pkg::cmd_t'(command);
  assign accept   = in_valid && in_ready;
  assign a_ext    = 32'(first_index);
  assign b_ext    = 32'(second_index);
  assign a_idx    = a_ext[IDX_W-1:0];
  assign b_idx    = b_ext[IDX_W-1:0];
  assign pair_ok  = (first_index != second_index) && (a_ext < SPIN_COUNT) && (b_ext < SPIN_COUNT);
  assign wen      = accept && (cmd == ige_pkg::CMD_WRITE) && pair_ok;
  assign waddr    = (a_idx < b_idx) ? {a_idx, b_idx} : {b_idx, a_idx};
  assign vin_wide = SW'(spin_vector);
  assign in_ready = idle;

  ige_coupling_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .wen   (wen),
    .waddr (waddr),
    .wdata (coupling_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  ige_seq #(
    .SPIN_COUNT (SPIN_COUNT)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (accept && (cmd != ige_pkg::CMD_WRITE)),
    .start_cmd   (cmd),
    .start_spins (vin_wide[SPIN_COUNT-1:0]),
    .max_passes  (max_passes),
    .raddr       (raddr),
    .rdata       (rdata),
    .res         (res),
    .res_ready   (res_ready),
    .idle        (idle)
  );

  assign res_ready = !out_valid || out_ready;

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    if (res.valid && res_ready) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_passes <= ige_pkg::PASS_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wen) begin
        max_passes <= cfg_wdata;
      end
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      energy       <= res.energy;
      result_spins <= res.spins;
    end
  end

endmodule
